[hdl/xee_pkg.sv]
// xee_pkg: shared types, constants and entity lookup for the xml entity escaper
// depends on nothing; used by xee_front, xee_fifo, xee_back and xml_entity_escaper
`default_nettype none

package xee_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] LEAD_BYTE = 8'hC2;
    localparam logic [7:0] NBSP_BYTE = 8'hA0;
    localparam logic [7:0] CHAR_AMP  = 8'h26;
    localparam logic [7:0] CHAR_LT   = 8'h3C;
    localparam logic [7:0] CHAR_GT   = 8'h3E;
    localparam logic [7:0] CHAR_QUOT = 8'h22;
    localparam logic [7:0] CHAR_APOS = 8'h27;

    typedef logic [2:0] kind_t;
    typedef logic [2:0] idx_t;

    localparam kind_t KIND_RAW1 = 3'd0;
    localparam kind_t KIND_RAW2 = 3'd1;
    localparam kind_t KIND_AMP  = 3'd2;
    localparam kind_t KIND_LT   = 3'd3;
    localparam kind_t KIND_GT   = 3'd4;
    localparam kind_t KIND_QUOT = 3'd5;
    localparam kind_t KIND_APOS = 3'd6;
    localparam kind_t KIND_NBSP = 3'd7;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } desc_t;

    localparam logic [0:0] REG_ATTR = 1'b0;
    localparam logic [0:0] REG_UTF8 = 1'b1;

    // number of output bytes for one descriptor
    function automatic idx_t kind_len(input kind_t kind);
        idx_t len;
        begin
            case (kind)
                KIND_RAW1: len = 3'd1;
                KIND_RAW2: len = 3'd2;
                KIND_AMP:  len = 3'd5;
                KIND_LT:   len = 3'd4;
                KIND_GT:   len = 3'd4;
                KIND_QUOT: len = 3'd6;
                KIND_APOS: len = 3'd6;
                KIND_NBSP: len = 3'd6;
                default:   len = 3'd1;
            endcase
            return len;
        end
    endfunction

    // byte number idx of the text a descriptor expands to
    function automatic logic [7:0] kind_char(input kind_t kind, input logic [7:0] data,
                                             input idx_t idx);
        logic [7:0] ch;
        begin
            ch = CHAR_AMP;
            case (kind)
                KIND_RAW1: ch = data;
                KIND_RAW2: ch = (idx == 3'd0) ? LEAD_BYTE : data;
                KIND_AMP:
                    case (idx)
                        3'd1:    ch = "a";
                        3'd2:    ch = "m";
                        3'd3:    ch = "p";
                        3'd4:    ch = ";";
                        default: ch = CHAR_AMP;
                    endcase
                KIND_LT:
                    case (idx)
                        3'd1:    ch = "l";
                        3'd2:    ch = "t";
                        3'd3:    ch = ";";
                        default: ch = CHAR_AMP;
                    endcase
                KIND_GT:
                    case (idx)
                        3'd1:    ch = "g";
                        3'd2:    ch = "t";
                        3'd3:    ch = ";";
                        default: ch = CHAR_AMP;
                    endcase
                KIND_QUOT:
                    case (idx)
                        3'd1:    ch = "q";
                        3'd2:    ch = "u";
                        3'd3:    ch = "o";
                        3'd4:    ch = "t";
                        3'd5:    ch = ";";
                        default: ch = CHAR_AMP;
                    endcase
                KIND_APOS:
                    case (idx)
                        3'd1:    ch = "a";
                        3'd2:    ch = "p";
                        3'd3:    ch = "o";
                        3'd4:    ch = "s";
                        3'd5:    ch = ";";
                        default: ch = CHAR_AMP;
                    endcase
                KIND_NBSP:
                    case (idx)
                        3'd1:    ch = "n";
                        3'd2:    ch = "b";
                        3'd3:    ch = "s";
                        3'd4:    ch = "p";
                        3'd5:    ch = ";";
                        default: ch = CHAR_AMP;
                    endcase
                default: ch = data;
            endcase
            return ch;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/xee_front.sv]
// xee_front: accepts input beats, classifies each byte and tracks a held utf-8 lead
// depends on xee_pkg
`default_nettype none

module xee_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           attr_ctx,
    input  wire logic           utf8,
    input  wire logic           in_valid,
    input  wire logic [7:0]     in_byte,
    input  wire logic           in_last,
    input  wire logic           q_full,
    output xee_pkg::desc_t      q_desc,
    output logic                q_push
);

    logic       pend_reg;
    logic       pend_next;
    logic       accept;
    logic       emit;
    xee_pkg::kind_t kind;

    assign accept = in_valid && !q_full;

    always_comb
    begin
        kind      = xee_pkg::KIND_RAW1;
        emit      = 1'b1;
        pend_next = pend_reg;
        if (pend_reg)
        begin
            // held lead resolves whatever the mode now says
            kind      = (in_byte == xee_pkg::NBSP_BYTE) ? xee_pkg::KIND_NBSP
                                                        : xee_pkg::KIND_RAW2;
            pend_next = 1'b0;
        end
        else if (in_byte == xee_pkg::CHAR_AMP)
            kind = xee_pkg::KIND_AMP;
        else if (in_byte == xee_pkg::CHAR_LT)
            kind = xee_pkg::KIND_LT;
        else if (in_byte == xee_pkg::CHAR_GT)
            kind = xee_pkg::KIND_GT;
        else if (attr_ctx && in_byte == xee_pkg::CHAR_QUOT)
            kind = xee_pkg::KIND_QUOT;
        else if (attr_ctx && in_byte == xee_pkg::CHAR_APOS)
            kind = xee_pkg::KIND_APOS;
        else if (!utf8 && in_byte == xee_pkg::NBSP_BYTE)
            kind = xee_pkg::KIND_NBSP;
        else if (utf8 && in_byte == xee_pkg::LEAD_BYTE && !in_last)
        begin
            // hold the lead; a lead on the last byte goes out raw
            emit      = 1'b0;
            pend_next = 1'b1;
        end
    end

    assign q_desc.kind = kind;
    assign q_desc.data = in_byte;
    assign q_desc.last = in_last;
    assign q_push      = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else if (accept)
            pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

[hdl/xee_fifo.sv]
// xee_fifo: short descriptor queue between the classifier and the expander
// depends on xee_pkg
`default_nettype none

module xee_fifo #(
    parameter int DEPTH = xee_pkg::FIFO_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire xee_pkg::desc_t wr_desc,
    output logic                full,
    input  wire logic           take,
    output xee_pkg::desc_t      rd_desc,
    output logic                avail
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xee_pkg::desc_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               do_push;
    logic               do_take;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign avail   = (cnt_reg != '0);
    assign do_push = push && !full;
    assign do_take = take && avail;
    assign rd_desc = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_take)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_take)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_take && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

[hdl/xee_back.sv]
// xee_back: expands one descriptor at a time into output beats
// depends on xee_pkg
`default_nettype none

module xee_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire xee_pkg::desc_t q_desc,
    input  wire logic           q_avail,
    output logic                q_take,
    input  wire logic           pop,
    output logic                empty,
    output logic [7:0]          out_byte,
    output logic                run_last,
    output logic                string_end
);

    xee_pkg::desc_t cur_reg;
    xee_pkg::idx_t  idx_reg;
    logic           valid_reg;
    logic           fin;
    logic           beat;

    assign fin        = (idx_reg == xee_pkg::kind_len(cur_reg.kind) - 3'd1);
    assign beat       = pop && valid_reg;
    assign empty      = !valid_reg;
    assign out_byte   = xee_pkg::kind_char(cur_reg.kind, cur_reg.data, idx_reg);
    assign run_last   = fin;
    assign string_end = fin && cur_reg.last;

    // reload on the final beat of a run so raw bytes keep one per cycle while pop stays high
    assign q_take = q_avail && (!valid_reg || (beat && fin));

    always_ff @(posedge clk)
    begin
        if (q_take)
            cur_reg <= q_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (q_take)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (beat)
        begin
            if (fin)
                valid_reg <= 1'b0;
            idx_reg <= fin ? '0 : idx_reg + 3'd1;
        end
    end

endmodule

`default_nettype wire

[hdl/xml_entity_escaper.sv]
// xml_entity_escaper: top level, config registers, classifier, queue and expander
// depends on xee_pkg, xee_front, xee_fifo, xee_back
// path: an accepted byte is written into the queue, then loaded into the expander's
// descriptor register, which drives its first output beat on the ports
// throughput: one input byte per cycle while bytes pass through and pop is held high;
// an escape gives one output beat per character of its entity (4 to 6), the queue
// of FIFO_DEPTH descriptors absorbs bursts; a held utf-8 lead gives no beat
// reset: queue, expander and lead hold emptied, both config registers cleared
`default_nettype none

module xml_entity_escaper #(
    parameter int FIFO_DEPTH = xee_pkg::FIFO_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  wire logic           push,
    output logic                full,
    input  wire logic [7:0]     data_byte,
    input  wire logic           is_last,
    output logic                empty,
    input  wire logic           pop,
    output logic [7:0]          out_byte,
    output logic                run_last,
    output logic                string_end
);

    logic           attr_reg;
    logic           utf8_reg;
    logic           cfg_wr;
    logic           q_full;
    logic           q_push;
    logic           q_take;
    logic           q_avail;
    xee_pkg::desc_t wr_desc;
    xee_pkg::desc_t rd_desc;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == xee_pkg::REG_UTF8) ? {31'd0, utf8_reg} : {31'd0, attr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= 1'b0;
            utf8_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == xee_pkg::REG_ATTR)
                attr_reg <= pwdata[0];
            else
                utf8_reg <= pwdata[0];
        end
    end

    assign full = q_full;

    xee_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .attr_ctx (attr_reg),
        .utf8     (utf8_reg),
        .in_valid (push),
        .in_byte  (data_byte),
        .in_last  (is_last),
        .q_full   (q_full),
        .q_desc   (wr_desc),
        .q_push   (q_push)
    );

    xee_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_desc (wr_desc),
        .full    (q_full),
        .take    (q_take),
        .rd_desc (rd_desc),
        .avail   (q_avail)
    );

    xee_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_desc     (rd_desc),
        .q_avail    (q_avail),
        .q_take     (q_take),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end)
    );

endmodule

`default_nettype wire
